[hdl/assert_macros.svh]
// Assertion macros used by the digit engine of the radix digit converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds on every clock edge outside reset.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Check that a condition never holds on a clock edge outside reset.
`define ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, prop)

`endif

`endif

[hdl/sitrd_pkg.sv]
// Package with shared constants, types and helpers of the radix digit converter.
`default_nettype none

package sitrd_pkg;

  localparam int unsigned DefMaxRadix = 16;
  localparam int unsigned MaxDigits   = 32;
  localparam int unsigned NumSyms     = 16;
  localparam int unsigned SymW        = 8;
  localparam int unsigned SymIdxW     = $clog2(NumSyms);
  localparam int unsigned RadixW      = 5;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned CntW        = $clog2(MaxDigits + 1);
  localparam int unsigned BufIdxW     = $clog2(MaxDigits);
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrW       = $clog2(QueueDepth);
  localparam int unsigned QCntW       = $clog2(QueueDepth + 1);
  localparam int unsigned BitsPerStep = 8;
  localparam int unsigned StepsPerDig = ValueW / BitsPerStep;
  localparam int unsigned StepW       = $clog2(StepsPerDig);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RADIX  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYM_LO = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SYM_HI = 2'd2;

  localparam logic [SymW-1:0] SIGN_CHAR = 8'h2D;
  localparam logic [SymW-1:0] PLUS_CHAR = 8'h2B;

  typedef struct packed {
    logic [RadixW-1:0]       radix;
    logic [NumSyms*SymW-1:0] symbols;
  } cfg_t;

  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
  } item_t;

  function automatic logic [SymW-1:0] symbol_of(cfg_t cfg, logic [SymIdxW-1:0] d);
    return cfg.symbols[{d, 3'b000} +: SymW];
  endfunction

endpackage

`default_nettype wire

[hdl/sitrd_front.sv]
// Front end: configuration registers, request intake, alphabet check and magnitude.
`default_nettype none

module sitrd_front #(
  parameter int unsigned MaxRadix = sitrd_pkg::DefMaxRadix
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [sitrd_pkg::ValueW-1:0]   value_i,
  output logic                                busy_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [sitrd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sitrd_pkg::CfgDataW-1:0] cfg_data_i,
  output sitrd_pkg::cfg_t                     cfg_o,
  output logic                                push_o,
  output sitrd_pkg::item_t                    push_item_o,
  input  wire logic                           full_i
);

  logic [sitrd_pkg::RadixW-1:0]   radix_q;
  logic [sitrd_pkg::CfgDataW-1:0] sym_lo_q, sym_hi_q;
  logic                           pend_q, pend_d;
  logic [sitrd_pkg::ValueW-1:0]   value_q;
  logic                           accept;
  logic                           alpha_ok;

  assign accept = start_i && !pend_q;
  assign busy_o = pend_q;

  assign cfg_o.radix   = radix_q;
  assign cfg_o.symbols = {sym_hi_q, sym_lo_q};

  // Alphabet check: range of radix, forbidden symbols, duplicates among used digits
  always_comb begin
    logic [sitrd_pkg::SymW-1:0] sa;
    alpha_ok = (radix_q >= sitrd_pkg::RadixW'(2)) &&
               (radix_q <= sitrd_pkg::RadixW'(MaxRadix));
    for (int a = 0; a < MaxRadix; a++) begin
      sa = cfg_o.symbols[a*sitrd_pkg::SymW +: sitrd_pkg::SymW];
      if (a < int'(radix_q)) begin
        if (sa == '0 || sa == sitrd_pkg::SIGN_CHAR || sa == sitrd_pkg::PLUS_CHAR) begin
          alpha_ok = 1'b0;
        end
      end
      for (int b = a + 1; b < MaxRadix; b++) begin
        if (b < int'(radix_q) &&
            cfg_o.symbols[b*sitrd_pkg::SymW +: sitrd_pkg::SymW] == sa) begin
          alpha_ok = 1'b0;
        end
      end
    end
  end

  assign push_item_o.neg = value_q[sitrd_pkg::ValueW-1];
  assign push_item_o.mag = value_q[sitrd_pkg::ValueW-1] ?
                           (sitrd_pkg::ValueW'(0) - value_q) : value_q;

  // Drop the request when the alphabet is bad; otherwise wait for queue space
  assign push_o = pend_q && alpha_ok && !full_i;

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (pend_q && (!alpha_ok || !full_i)) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      radix_q  <= '0;
      sym_lo_q <= '0;
      sym_hi_q <= '0;
    end else begin
      pend_q <= pend_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sitrd_pkg::CFG_RADIX:  radix_q  <= cfg_data_i[sitrd_pkg::RadixW-1:0];
          sitrd_pkg::CFG_SYM_LO: sym_lo_q <= cfg_data_i;
          sitrd_pkg::CFG_SYM_HI: sym_hi_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_i;
    end
  end

endmodule

`default_nettype wire

[hdl/sitrd_queue.sv]
// Short request queue between the front end and the digit engine.
`default_nettype none

module sitrd_queue (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire sitrd_pkg::item_t push_item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output sitrd_pkg::item_t pop_item_o,
  output logic       empty_o
);

  sitrd_pkg::item_t               mem_q [sitrd_pkg::QueueDepth];
  logic [sitrd_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [sitrd_pkg::QCntW-1:0]    cnt_q;

  assign full_o     = (cnt_q == sitrd_pkg::QCntW'(sitrd_pkg::QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  function automatic logic [sitrd_pkg::QPtrW-1:0] ptr_inc(logic [sitrd_pkg::QPtrW-1:0] p);
    return (p == sitrd_pkg::QPtrW'(sitrd_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[hdl/sitrd_back.sv]
// Digit engine: iterative division by the radix, digit buffer and character output.
`default_nettype none
`include "assert_macros.svh"

module sitrd_back #(
  parameter int unsigned MaxRadix = sitrd_pkg::DefMaxRadix
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sitrd_pkg::cfg_t             cfg_i,
  input  wire logic                        empty_i,
  input  wire sitrd_pkg::item_t            pop_item_i,
  output logic                             pop_o,
  output logic                             strobe_o,
  output logic [sitrd_pkg::SymW-1:0]       character_o,
  output logic                             last_o
);

  localparam int unsigned DigW = (MaxRadix > 2) ? $clog2(MaxRadix) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic [sitrd_pkg::ValueW-1:0]     quo_q, quo_d;
  logic [DigW-1:0]                  rem_q, rem_d;
  logic [sitrd_pkg::StepW-1:0]      step_q, step_d;
  logic [sitrd_pkg::CntW-1:0]       nd_q, nd_d, nd_m1;
  logic                             strobe_q, strobe_d;
  logic [sitrd_pkg::SymW-1:0]       char_q, char_d;
  logic                             last_q, last_d;
  logic [DigW-1:0]                  buf_q [sitrd_pkg::MaxDigits];
  logic                             buf_we;
  logic [sitrd_pkg::BufIdxW-1:0]    rd_idx;
  logic [DigW:0]                    radix_ext;
  logic [sitrd_pkg::ValueW-1:0]     quo_nx;
  logic [DigW-1:0]                  rem_nx;
  logic                             dig_done;

  assign radix_ext = (DigW + 1)'(cfg_i.radix);
  assign nd_m1     = nd_q - sitrd_pkg::CntW'(1);
  assign rd_idx    = nd_m1[sitrd_pkg::BufIdxW-1:0];
  assign dig_done  = (step_q == sitrd_pkg::StepW'(sitrd_pkg::StepsPerDig - 1));

  // Restoring division, BitsPerStep quotient bits per step
  always_comb begin
    logic [DigW:0]                t;
    logic [sitrd_pkg::ValueW-1:0] q;
    logic [DigW-1:0]              r;
    q = quo_q;
    r = rem_q;
    for (int i = 0; i < sitrd_pkg::BitsPerStep; i++) begin
      t = {r, q[sitrd_pkg::ValueW-1]};
      q = {q[sitrd_pkg::ValueW-2:0], 1'b0};
      if (t >= radix_ext) begin
        t    = t - radix_ext;
        q[0] = 1'b1;
      end
      r = t[DigW-1:0];
    end
    quo_nx = q;
    rem_nx = r;
  end

  always_comb begin
    state_d  = state_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    step_d   = step_q;
    nd_d     = nd_q;
    strobe_d = 1'b0;
    char_d   = char_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    buf_we   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          quo_d   = pop_item_i.mag;
          rem_d   = '0;
          step_d  = '0;
          nd_d    = '0;
          state_d = ST_DIV;
          if (pop_item_i.neg) begin
            strobe_d = 1'b1;
            char_d   = sitrd_pkg::SIGN_CHAR;
            last_d   = 1'b0;
          end
        end
      end
      ST_DIV: begin
        quo_d  = quo_nx;
        rem_d  = rem_nx;
        step_d = step_q + 1'b1;
        if (dig_done) begin
          buf_we = 1'b1;
          nd_d   = nd_q + 1'b1;
          rem_d  = '0;
          if (quo_nx == '0 ||
              nd_q == sitrd_pkg::CntW'(sitrd_pkg::MaxDigits - 1)) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        strobe_d = 1'b1;
        last_d   = (nd_q == sitrd_pkg::CntW'(1));
        nd_d     = nd_m1;
        if (nd_q == sitrd_pkg::CntW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      nd_q     <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      nd_q     <= nd_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  // Read the digit buffer from the top down while emitting
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (state_q == ST_EMIT) begin
      char_q <= sitrd_pkg::symbol_of(cfg_i, sitrd_pkg::SymIdxW'(buf_q[rd_idx]));
    end else begin
      char_q <= char_d;
    end
    if (buf_we) begin
      buf_q[nd_q[sitrd_pkg::BufIdxW-1:0]] <= rem_nx;
    end
  end

  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  `ASSERT_PROP(a_rem_below_radix, (state_q == ST_DIV) |-> ({1'b0, rem_q} < radix_ext))
  `ASSERT_PROP(a_last_from_emit, (strobe_q && last_q) |-> $past(state_q == ST_EMIT))
  `ASSERT_NEVER(a_emit_empty_buf, (state_q == ST_EMIT) && (nd_q == '0))
  `ASSERT_NEVER(a_buf_overrun, (state_q == ST_DIV) && (nd_q >= sitrd_pkg::CntW'(sitrd_pkg::MaxDigits)))

endmodule

`default_nettype wire

[hdl/signed_int_to_radix_digits.sv]
// Top level of the signed integer to radix digit string converter.
//
//   channel   handshake               payload                      direction
//   request   start_i / busy_o        value_i                      in
//   result    strobe_o                character_o, last_o          out
//   config    cfg_we_i                cfg_idx_i, cfg_data_i        in
//
// A request is taken at an edge with start_i high and busy_o low; busy_o then stays
// high while the front end checks the alphabet and forms the magnitude, until the
// request is queued or dropped. The engine fetches a request, divides it by the radix
// digit by digit (8 quotient bits a cycle) and emits one character a cycle. A
// two-entry queue lets the front end take requests meanwhile; strobe_o cannot be
// stalled. Reset clears control state and the configuration, so nothing comes out
// until a valid alphabet is written.
`default_nettype none

module signed_int_to_radix_digits #(
  parameter int unsigned MaxRadix = sitrd_pkg::DefMaxRadix
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic signed [sitrd_pkg::ValueW-1:0]   value_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic        [sitrd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic        [sitrd_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                                       strobe_o,
  output logic             [sitrd_pkg::SymW-1:0]     character_o,
  output logic                                       last_o
);

  sitrd_pkg::cfg_t  cfg;
  sitrd_pkg::item_t push_item, pop_item;
  logic             push, pop, full, empty;

  // Intake, configuration and classification; drop requests with a bad alphabet
  sitrd_front #(
    .MaxRadix(MaxRadix)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .value_i    (value_i),
    .busy_o     (busy_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .push_o     (push),
    .push_item_o(push_item),
    .full_i     (full)
  );

  // Hold classified requests until the engine is free
  sitrd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (full),
    .pop_i      (pop),
    .pop_item_o (pop_item),
    .empty_o    (empty)
  );

  // Divide out digits least significant first, then emit them most significant first
  sitrd_back #(
    .MaxRadix(MaxRadix)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .empty_i    (empty),
    .pop_item_i (pop_item),
    .pop_o      (pop),
    .strobe_o   (strobe_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire
